FILE: design/cpsa_pkg.sv
// Package: shared types and constants of the contiguous page segment allocator.
`default_nettype none
package cpsa_pkg;
    localparam logic [1:0] K_ALLOC = 2'd0;
    localparam logic [1:0] K_FREE  = 2'd1;
    localparam logic [1:0] K_READ  = 2'd2;
    localparam logic [1:0] K_WRITE = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSPC  = 2'd1;
    localparam logic [1:0] ST_NOPID  = 2'd2;

    localparam logic [10:0] TOTAL_RESET = 11'd256;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOOK  = 8'b0000_0010,
        S_DEC   = 8'b0000_0100,
        S_FSCAN = 8'b0000_1000,
        S_FSTEP = 8'b0001_0000,
        S_CSCAN = 8'b0010_0000,
        S_CSTEP = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;
endpackage
`default_nettype wire

FILE: design/contiguous_page_segment_allocator_unit.sv
// Top level: segment table, sequencer and shared address-order scan unit.
// Usage: raise start with kind/pid/page_count/page_in_process while busy is low.
// The item is taken on that edge; busy stays high until the result beat,
// which appears on the o_ ports for exactly one cycle with o_done high.
// The receiver cannot stall; results are never held.
// Sequence: a lookup pass over MAX_SEGMENTS entries (one entry per cycle), a
// decode state and an output state (S_DONE) for every item. An allocate adds a
// first-fit walk: each step is one min-base search over the table plus a step
// state, up to one step per live segment plus one. Compaction adds the same
// again plus a second first-fit walk.
// busy is low again while o_done is high, so the next item can be taken at the
// edge that ends the result beat.
// Config: i_cfg_valid/o_cfg_ready write total_pages; ready is high while idle.
// Reset (synchronous, i_rst_n low) clears all valid bits and sets total_pages 256.
`default_nettype none
module contiguous_page_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = 16,
    parameter int MAX_PAGES    = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_pid,
    input  wire logic [10:0] i_page_count,
    input  wire logic [9:0]  i_page_in_process,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_data,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [9:0]       o_segment_start,
    output logic [9:0]       o_absolute_page,
    output logic [15:0]      o_reads_done,
    output logic [15:0]      o_writes_done,
    output logic             o_compacted
);
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int AW = $clog2(MAX_PAGES) + 1;   // holds MAX_PAGES itself
    localparam int UW = AW + IW + 1;             // sum of lengths
    localparam logic [IW:0] LAST = (IW+1)'(MAX_SEGMENTS - 1);

    logic [MAX_SEGMENTS-1:0] r_valid, n_valid;
    logic [MAX_SEGMENTS-1:0] r_seen, n_seen;
    logic [15:0]    r_owner [MAX_SEGMENTS];
    logic [AW-1:0]  r_base  [MAX_SEGMENTS];
    logic [AW-1:0]  r_len   [MAX_SEGMENTS];
    logic [15:0]    r_rdc   [MAX_SEGMENTS];
    logic [15:0]    r_wrc   [MAX_SEGMENTS];

    cpsa_pkg::t_state r_state, n_state;
    logic [10:0]   r_total;
    logic [1:0]    r_kind;
    logic [15:0]   r_pid;
    logic [10:0]   r_cnt;
    logic [9:0]    r_pip;
    logic [IW:0]   r_i, n_i;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_k, n_k;
    logic          r_slot_ok, n_slot_ok;
    logic [IW-1:0] r_slot, n_slot;
    logic [UW-1:0] r_used, n_used;
    logic          r_best_ok, n_best_ok;
    logic [IW-1:0] r_best, n_best;
    logic [AW-1:0] r_cursor, n_cursor;
    logic          r_comp, n_comp;
    logic [1:0]    r_st, n_st;
    logic [AW-1:0] r_start, n_start;

    logic [AW-1:0] area;
    logic [IW-1:0] idx;
    logic [AW:0]   seg_end, gap_end;
    logic          fit;
    logic          wr_alloc, wr_base;
    logic [AW-1:0] off;

    assign idx  = r_i[IW-1:0];
    assign area = ({21'd0, r_total} > 32'(MAX_PAGES)) ? AW'(MAX_PAGES) : AW'(r_total);
    assign busy = (r_state != cpsa_pkg::S_IDLE);
    assign o_cfg_ready = !busy;

    // gap check for the current first-fit step
    always_comb begin
        seg_end = {1'b0, r_base[r_best]} + {1'b0, r_len[r_best]};
        gap_end = {1'b0, area};
        if (r_best_ok && r_base[r_best] < area) gap_end = {1'b0, r_base[r_best]};
        fit = (gap_end > {1'b0, r_cursor}) &&
              (gap_end - {1'b0, r_cursor} >= (AW+1)'(r_cnt));
        off = ((AW+1)'(r_pip) < {1'b0, r_len[r_k]}) ? AW'(r_pip) : r_len[r_k] - 1'b1;
    end

    always_comb begin
        n_state = r_state; n_i = r_i; n_hit = r_hit; n_k = r_k;
        n_slot_ok = r_slot_ok; n_slot = r_slot; n_used = r_used;
        n_best_ok = r_best_ok; n_best = r_best; n_cursor = r_cursor;
        n_comp = r_comp; n_st = r_st; n_start = r_start;
        n_valid = r_valid; n_seen = r_seen;
        wr_alloc = 1'b0; wr_base = 1'b0;
        unique case (r_state)
            cpsa_pkg::S_IDLE: begin
                if (start) begin
                    n_state = cpsa_pkg::S_LOOK; n_i = '0; n_hit = 1'b0;
                    n_slot_ok = 1'b0; n_used = '0; n_comp = 1'b0;
                    n_st = cpsa_pkg::ST_OK; n_start = '0;
                end
            end
            cpsa_pkg::S_LOOK: begin
                if (r_valid[idx]) begin
                    n_used = r_used + UW'(r_len[idx]);
                    if (!r_hit && r_owner[idx] == r_pid) begin
                        n_hit = 1'b1; n_k = idx;
                    end
                end else if (!r_slot_ok) begin
                    n_slot_ok = 1'b1; n_slot = idx;
                end
                n_i = r_i + 1'b1;
                if (r_i == LAST) n_state = cpsa_pkg::S_DEC;
            end
            cpsa_pkg::S_DEC: begin
                n_state = cpsa_pkg::S_DONE;
                if (r_kind == cpsa_pkg::K_ALLOC) begin
                    if (r_cnt == '0 || r_hit || !r_slot_ok ||
                        (UW'(area) < r_used) || (UW'(area) - r_used < UW'(r_cnt))) begin
                        n_st = cpsa_pkg::ST_NOSPC;
                    end else begin
                        n_state = cpsa_pkg::S_FSCAN; n_seen = '0; n_cursor = '0;
                        n_i = '0; n_best_ok = 1'b0;
                    end
                end else if (!r_hit) begin
                    n_st = cpsa_pkg::ST_NOPID;
                end else if (r_kind == cpsa_pkg::K_FREE) begin
                    n_valid[r_k] = 1'b0;
                end
            end
            cpsa_pkg::S_FSCAN, cpsa_pkg::S_CSCAN: begin
                if (r_valid[idx] && !r_seen[idx] &&
                    (!r_best_ok || r_base[idx] < r_base[r_best])) begin
                    n_best_ok = 1'b1; n_best = idx;
                end
                n_i = r_i + 1'b1;
                if (r_i == LAST)
                    n_state = (r_state == cpsa_pkg::S_FSCAN) ? cpsa_pkg::S_FSTEP
                                                             : cpsa_pkg::S_CSTEP;
            end
            cpsa_pkg::S_FSTEP: begin
                n_i = '0; n_best_ok = 1'b0;
                if (fit) begin
                    n_start = r_cursor; wr_alloc = 1'b1;
                    n_valid[r_slot] = 1'b1; n_state = cpsa_pkg::S_DONE;
                end else if (!r_best_ok) begin
                    if (r_comp) begin
                        n_st = cpsa_pkg::ST_NOSPC; n_state = cpsa_pkg::S_DONE;
                    end else begin
                        n_comp = 1'b1; n_seen = '0; n_cursor = '0;
                        n_state = cpsa_pkg::S_CSCAN;
                    end
                end else begin
                    n_seen[r_best] = 1'b1;
                    if (seg_end > {1'b0, r_cursor}) n_cursor = AW'(seg_end);
                    n_state = cpsa_pkg::S_FSCAN;
                end
            end
            cpsa_pkg::S_CSTEP: begin
                n_i = '0; n_best_ok = 1'b0;
                if (!r_best_ok) begin
                    n_seen = '0; n_cursor = '0; n_state = cpsa_pkg::S_FSCAN;
                end else begin
                    n_seen[r_best] = 1'b1; wr_base = 1'b1;
                    n_cursor = r_cursor + r_len[r_best];
                    n_state = cpsa_pkg::S_CSCAN;
                end
            end
            cpsa_pkg::S_DONE: n_state = cpsa_pkg::S_IDLE;
            default: n_state = cpsa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpsa_pkg::S_IDLE;
            r_valid <= '0;
            r_total <= cpsa_pkg::TOTAL_RESET;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            o_done  <= (r_state == cpsa_pkg::S_DONE);
            if (i_cfg_valid && o_cfg_ready) r_total <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_hit <= n_hit; r_k <= n_k; r_slot_ok <= n_slot_ok;
        r_slot <= n_slot; r_used <= n_used; r_best_ok <= n_best_ok;
        r_best <= n_best; r_cursor <= n_cursor; r_comp <= n_comp;
        r_st <= n_st; r_start <= n_start; r_seen <= n_seen;
        if (r_state == cpsa_pkg::S_IDLE && start) begin
            r_kind <= i_kind; r_pid <= i_pid;
            r_cnt <= i_page_count; r_pip <= i_page_in_process;
        end
        if (wr_alloc) begin
            r_owner[r_slot] <= r_pid;
            r_base[r_slot]  <= r_cursor;
            r_len[r_slot]   <= AW'(r_cnt);
            r_rdc[r_slot]   <= '0;
            r_wrc[r_slot]   <= '0;
        end
        if (wr_base) r_base[r_best] <= r_cursor;
        if (r_state == cpsa_pkg::S_DEC && r_hit) begin
            if (r_kind == cpsa_pkg::K_READ && r_rdc[r_k] != 16'hFFFF)
                r_rdc[r_k] <= r_rdc[r_k] + 16'd1;
            if (r_kind == cpsa_pkg::K_WRITE && r_wrc[r_k] != 16'hFFFF)
                r_wrc[r_k] <= r_wrc[r_k] + 16'd1;
        end
        if (r_state == cpsa_pkg::S_DEC) begin
            o_segment_start <= '0; o_absolute_page <= '0;
            o_reads_done <= '0; o_writes_done <= '0;
            if (r_kind != cpsa_pkg::K_ALLOC && r_hit) begin
                if (r_kind == cpsa_pkg::K_FREE) begin
                    o_segment_start <= r_base[r_k][9:0];
                    o_reads_done <= r_rdc[r_k]; o_writes_done <= r_wrc[r_k];
                end else begin
                    o_absolute_page <= 10'(r_base[r_k] + off);
                end
            end
        end
        if (r_state == cpsa_pkg::S_DONE) begin
            o_status <= r_st;
            o_compacted <= r_comp;
            if (r_kind == cpsa_pkg::K_ALLOC)
                o_segment_start <= (r_st == cpsa_pkg::ST_OK) ? r_start[9:0] : 10'd0;
        end
    end
endmodule
`default_nettype wire

FILE: design/cpsa_checker.sv
// Checker: port-level properties of the allocator, bound to the top level.
`default_nettype none
module cpsa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic [1:0] o_status,
    input wire logic       o_compacted,
    input wire logic       o_cfg_ready
);
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("beat while busy");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_status == cpsa_pkg::ST_OK || o_status == cpsa_pkg::ST_NOSPC ||
                     o_status == cpsa_pkg::ST_NOPID) &&
                    (!o_compacted || o_status == cpsa_pkg::ST_OK)))
        else $error("bad status");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !busy) else $error("cfg ready while busy");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double beat");
endmodule
bind contiguous_page_segment_allocator_unit cpsa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_status(o_status), .o_compacted(o_compacted),
    .o_cfg_ready(o_cfg_ready)
);
`default_nettype wire

FILE: tb/sv/contiguous_page_segment_allocator_unit_tb.sv
// Testbench: checks the segment allocator against a behavioral model of its table.
`default_nettype none
module contiguous_page_segment_allocator_unit_tb;

    localparam int SEGS  = 16;
    localparam int PAGES = 1024;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  seg_start;
        logic [9:0]  abs_page;
        logic [15:0] reads;
        logic [15:0] writes;
        logic        comp;
    } t_alloc_result;

    typedef struct {
        logic [1:0]    kind;
        logic [15:0]   pid;
        logic [10:0]   count;
        logic [9:0]    page;
        bit            typed;
        t_alloc_result want;
    } t_stim_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_kind = '0;
    logic [15:0] i_pid = '0;
    logic [10:0] i_page_count = '0;
    logic [9:0]  i_page_in_process = '0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [9:0]  o_segment_start;
    logic [9:0]  o_absolute_page;
    logic [15:0] o_reads_done;
    logic [15:0] o_writes_done;
    logic        o_compacted;

    contiguous_page_segment_allocator_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_pid(i_pid), .i_page_count(i_page_count),
        .i_page_in_process(i_page_in_process),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_status(o_status), .o_segment_start(o_segment_start),
        .o_absolute_page(o_absolute_page), .o_reads_done(o_reads_done),
        .o_writes_done(o_writes_done), .o_compacted(o_compacted)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // model of the segment table
    int  area_cfg;
    bit  seg_live [SEGS];
    int  seg_owner [SEGS];
    int  seg_base [SEGS];
    int  seg_len [SEGS];
    int  seg_reads [SEGS];
    int  seg_writes [SEGS];
    bit  visited [SEGS];

    t_alloc_result pending_results [$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 0;

    function automatic int area_pages();
        return (area_cfg > PAGES) ? PAGES : area_cfg;
    endfunction

    function automatic int find_pid(int pid);
        for (int i = 0; i < SEGS; i++)
            if (seg_live[i] && seg_owner[i] == pid) return i;
        return -1;
    endfunction

    function automatic int lowest_unvisited();
        int best;
        best = -1;
        for (int i = 0; i < SEGS; i++)
            if (seg_live[i] && !visited[i] && (best < 0 || seg_base[i] < seg_base[best]))
                best = i;
        return best;
    endfunction

    function automatic bit place_first_fit(int need, output int at);
        int cursor, k, stop;
        cursor = 0;
        at = 0;
        for (int i = 0; i < SEGS; i++) visited[i] = 0;
        forever begin
            k = lowest_unvisited();
            stop = area_pages();
            if (k >= 0 && seg_base[k] < stop) stop = seg_base[k];
            if (stop > cursor && stop - cursor >= need) begin
                at = cursor;
                return 1;
            end
            if (k < 0) return 0;
            visited[k] = 1;
            if (seg_base[k] + seg_len[k] > cursor) cursor = seg_base[k] + seg_len[k];
        end
    endfunction

    function automatic void pack_segments();
        int cursor, k;
        cursor = 0;
        for (int i = 0; i < SEGS; i++) visited[i] = 0;
        k = lowest_unvisited();
        while (k >= 0) begin
            visited[k] = 1;
            seg_base[k] = cursor;
            cursor += seg_len[k];
            k = lowest_unvisited();
        end
    endfunction

    function automatic t_alloc_result predict_item(logic [1:0] kind, int pid, int need,
                                                   int page);
        t_alloc_result r;
        int k, slot, used, spare, at, off;
        r = '0;
        k = find_pid(pid);
        if (kind == cpsa_pkg::K_ALLOC) begin
            slot = -1;
            used = 0;
            for (int i = 0; i < SEGS; i++)
                if (seg_live[i]) used += seg_len[i];
                else if (slot < 0) slot = i;
            spare = (area_pages() > used) ? area_pages() - used : 0;
            if (need == 0 || k >= 0 || slot < 0 || spare < need) begin
                r.status = cpsa_pkg::ST_NOSPC;
            end else begin
                if (!place_first_fit(need, at)) begin
                    pack_segments();
                    r.comp = 1;
                    if (!place_first_fit(need, at)) r.status = cpsa_pkg::ST_NOSPC;
                end
                if (r.status == cpsa_pkg::ST_OK) begin
                    seg_live[slot] = 1;
                    seg_owner[slot] = pid;
                    seg_base[slot] = at;
                    seg_len[slot] = need;
                    seg_reads[slot] = 0;
                    seg_writes[slot] = 0;
                    r.seg_start = at[9:0];
                end
            end
        end else if (k < 0) begin
            r.status = cpsa_pkg::ST_NOPID;
        end else if (kind == cpsa_pkg::K_FREE) begin
            r.seg_start = seg_base[k][9:0];
            r.reads = seg_reads[k][15:0];
            r.writes = seg_writes[k][15:0];
            seg_live[k] = 0;
        end else begin
            off = (page < seg_len[k]) ? page : seg_len[k] - 1;
            r.abs_page = 10'(seg_base[k] + off);
            if (kind == cpsa_pkg::K_READ) begin
                if (seg_reads[k] < 65535) seg_reads[k]++;
            end else begin
                if (seg_writes[k] < 65535) seg_writes[k]++;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("** contiguous_page_segment_allocator_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result got, want;
        if (i_rst_n && o_done) begin
            got = {o_status, o_segment_start, o_absolute_page, o_reads_done,
                   o_writes_done, o_compacted};
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result beat: %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    errors++;
                    $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                end
                if (got.seg_start !== want.seg_start) begin
                    errors++;
                    $display("%0t segment_start exp %0d got %0d", $time, want.seg_start,
                             got.seg_start);
                end
                if (got.abs_page !== want.abs_page) begin
                    errors++;
                    $display("%0t absolute_page exp %0d got %0d", $time, want.abs_page,
                             got.abs_page);
                end
                if (got.reads !== want.reads) begin
                    errors++;
                    $display("%0t reads_done exp %0d got %0d", $time, want.reads, got.reads);
                end
                if (got.writes !== want.writes) begin
                    errors++;
                    $display("%0t writes_done exp %0d got %0d", $time, want.writes,
                             got.writes);
                end
                if (got.comp !== want.comp) begin
                    errors++;
                    $display("%0t compacted exp %0d got %0d", $time, want.comp, got.comp);
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue_item(logic [1:0] kind, logic [15:0] pid, logic [10:0] need,
                              logic [9:0] page, bit typed, t_alloc_result want);
        t_alloc_result r;
        while (!quiet && $urandom_range(99) < 21) begin
            start = 0;
            @(negedge i_clk);
        end
        start = 1;
        i_kind = kind;
        i_pid = pid;
        i_page_count = need;
        i_page_in_process = page;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        r = predict_item(kind, pid, need, page);
        pending_results.push_back(typed ? want : r);
        @(negedge i_clk);
        start = 0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_area(logic [10:0] pages);
        drain();
        i_cfg_valid = 1;
        i_cfg_data = pages;
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        area_cfg = pages;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    function automatic t_alloc_result res(logic [1:0] st, int s);
        t_alloc_result r;
        r = '0;
        r.status = st;
        r.seg_start = s[9:0];
        return r;
    endfunction

    t_stim_row directed [$];
    logic [10:0] area_steps [] = '{11'd1024, 11'd2047, 11'd0, 11'd1, 11'd16,
                                   11'd300, 11'd40, 11'd512, 11'd100};

    initial begin
        int a, r, need, n;
        logic [1:0] kind;
        logic [15:0] pid;
        area_cfg = cpsa_pkg::TOTAL_RESET;
        for (int i = 0; i < SEGS; i++) seg_live[i] = 0;

        directed = '{
            '{cpsa_pkg::K_READ,  16'd5,    11'd0,    10'd0,    1,
              res(cpsa_pkg::ST_NOPID, 0)},
            '{cpsa_pkg::K_ALLOC, 16'd0,    11'd0,    10'd0,    1,
              res(cpsa_pkg::ST_NOSPC, 0)},
            '{cpsa_pkg::K_ALLOC, 16'd0,    11'd2047, 10'd0,    1,
              res(cpsa_pkg::ST_NOSPC, 0)},
            '{cpsa_pkg::K_ALLOC, 16'd1,    11'd100,  10'd0,    1,
              res(cpsa_pkg::ST_OK, 0)},
            '{cpsa_pkg::K_ALLOC, 16'd1,    11'd5,    10'd0,    1,
              res(cpsa_pkg::ST_NOSPC, 0)},
            '{cpsa_pkg::K_ALLOC, 16'd2,    11'd100,  10'd0,    1,
              res(cpsa_pkg::ST_OK, 100)},
            '{cpsa_pkg::K_ALLOC, 16'hFFFF, 11'd56,   10'd0,    1,
              res(cpsa_pkg::ST_OK, 200)},
            '{cpsa_pkg::K_READ,  16'd2,    11'd0,    10'd3,    0, '0},
            '{cpsa_pkg::K_WRITE, 16'd2,    11'd0,    10'd1023, 0, '0},
            '{cpsa_pkg::K_FREE,  16'd2,    11'd0,    10'd0,    0, '0},
            '{cpsa_pkg::K_ALLOC, 16'd4,    11'd80,   10'd0,    1,
              res(cpsa_pkg::ST_OK, 100)},
            '{cpsa_pkg::K_FREE,  16'd1,    11'd0,    10'd0,    0, '0},
            '{cpsa_pkg::K_ALLOC, 16'd5,    11'd110,  10'd0,    0, '0},
            '{cpsa_pkg::K_READ,  16'd5,    11'd0,    10'd1023, 0, '0},
            '{cpsa_pkg::K_WRITE, 16'd5,    11'd0,    10'd0,    0, '0},
            '{cpsa_pkg::K_WRITE, 16'd7,    11'd0,    10'd0,    1,
              res(cpsa_pkg::ST_NOPID, 0)},
            '{cpsa_pkg::K_FREE,  16'd7,    11'd0,    10'd0,    1,
              res(cpsa_pkg::ST_NOPID, 0)},
            '{cpsa_pkg::K_FREE,  16'd5,    11'd0,    10'd0,    0, '0},
            '{cpsa_pkg::K_READ,  16'hFFFF, 11'd0,    10'd55,   0, '0},
            '{cpsa_pkg::K_FREE,  16'hFFFF, 11'd0,    10'd0,    0, '0}
        };

        repeat (9) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        foreach (directed[i])
            issue_item(directed[i].kind, directed[i].pid, directed[i].count,
                       directed[i].page, directed[i].typed, directed[i].want);

        n = 0;
        foreach (area_steps[p]) begin
            write_area(area_steps[p]);
            for (int j = 0; j < 70; j++) begin
                quiet = (n >= 200 && n < 300);
                if (n == 400) drain();
                a = area_pages();
                r = $urandom_range(99);
                kind = (r < 40) ? cpsa_pkg::K_ALLOC : (r < 60) ? cpsa_pkg::K_FREE :
                       (r < 80) ? cpsa_pkg::K_READ : cpsa_pkg::K_WRITE;
                r = $urandom_range(99);
                pid = (r < 3) ? 16'hFFFF : (r < 8) ? 16'($urandom) : 16'($urandom_range(20));
                r = $urandom_range(99);
                if (a == 0 || r < 5) need = $urandom_range(15);
                else if (r < 10) need = $urandom_range(2047, 1);
                else if (r < 15) need = a;
                else need = $urandom_range((a / 6 > 1) ? a / 6 : 1, 1);
                issue_item(kind, pid, 11'(need), 10'($urandom), 0, '0);
                n++;
            end
        end

        drain();
        repeat (900) @(negedge i_clk);
        if (errors == 0) begin
            $display("** contiguous_page_segment_allocator_unit: PASSED **");
        end else begin
            $display("** contiguous_page_segment_allocator_unit: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
